/* hw/rtl/scb_pkg.sv */
// Shared types and constants for the SPI command register bank.
`timescale 1ns / 1ps
`default_nettype none
package scb_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = $clog2(DEPTH);
  localparam int MAX_RUN = 64;
  localparam int Q_DEPTH = 4;
  localparam int QPW     = $clog2(Q_DEPTH);

  localparam logic [8:0] DEPTH_L   = 9'(DEPTH);
  localparam logic [8:0] MAX_RUN_L = 9'(MAX_RUN);
  localparam logic [QPW:0] Q_DEPTH_L = (QPW + 1)'(Q_DEPTH);

  // input item modes
  localparam logic [1:0] FN_SPI   = 2'd0;
  localparam logic [1:0] FN_LOCAL = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // SPI opcodes
  localparam logic [7:0] OP_READ  = 8'd0;
  localparam logic [7:0] OP_WRITE = 8'd1;
  localparam logic [7:0] OP_RANGE = 8'd2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  idx;
    logic [8:0]  stop;
    logic [7:0]  val;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } res_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

endpackage
`default_nettype wire

/* hw/rtl/spi_command_register_bank_top.sv */
// Top level of the SPI command register bank.
//
// Input items enter on push/full; each carries a mode (SPI byte, local
// write or clear), the SPI byte with its frame-start flag, and a local
// index/value pair. Results leave on empty/pop as tx byte plus a last flag.
// An input item is taken every cycle while the 4-entry command queue has
// room; only decoded commands (third frame byte, local write, clear) go
// into that queue. The back end runs one command at a time: a write or a
// clear is done as it is popped; a read run sends one entry per cycle
// while the result queue has room, through a registered store read into
// a 4-entry result queue. When the receiver stops popping, the result
// queue fills, the read run pauses, the command queue fills and full rises;
// nothing is lost. Reset zeroes the store at once (per-entry valid flags)
// and the frame byte count, so the block is ready in the first cycle
// after reset.
`timescale 1ns / 1ps
`default_nettype none
module spi_command_register_bank_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_frame_start,
  input  wire logic [5:0] in_local_index,
  input  wire logic [7:0] in_local_value,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_tx_byte,
  output logic            out_last_byte
);
  import scb_pkg::*;

  cmd_t         f_cmd, q_cmd;
  logic         f_push, q_empty, q_pop;
  logic [QPW:0] oq_level;
  logic         r_push;
  res_t         r_res, o_res;

  scb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (push && !full),
    .func        (in_func),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .local_index (in_local_index),
    .local_value (in_local_value),
    .cmd         (f_cmd),
    .cmd_push    (f_push)
  );

  scb_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_cmd),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_cmd),
    .empty (q_empty)
  );

  scb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .oq_level  (oq_level),
    .res_push  (r_push),
    .res       (r_res)
  );

  scb_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .din   (r_res),
    .level (oq_level),
    .pop   (pop),
    .dout  (o_res),
    .empty (empty)
  );

  assign out_tx_byte   = o_res.tx;
  assign out_last_byte = o_res.last;

endmodule
`default_nettype wire

/* hw/rtl/scb_front.sv */
// Front end: SPI frame tracking and command decode.
`timescale 1ns / 1ps
`default_nettype none
module scb_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [1:0]    func,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          frame_start,
  input  wire logic [5:0]    local_index,
  input  wire logic [7:0]    local_value,
  output scb_pkg::cmd_t      cmd,
  output logic               cmd_push
);
  import scb_pkg::*;

  logic [1:0] bcnt_r, bcnt_nxt, cnt;
  logic [7:0] opcode_r, opcode_nxt;
  logic [7:0] arg1_r, arg1_nxt;
  logic [8:0] stop_a, lim, stop_b;

  always_comb begin
    stop_a = ({1'b0, rx_byte} > DEPTH_L) ? DEPTH_L : {1'b0, rx_byte};
    lim    = {1'b0, arg1_r} + MAX_RUN_L;
    stop_b = (stop_a > lim) ? lim : stop_a;
  end

  always_comb begin
    cnt        = frame_start ? 2'd0 : bcnt_r;
    bcnt_nxt   = bcnt_r;
    opcode_nxt = opcode_r;
    arg1_nxt   = arg1_r;
    cmd        = '0;
    cmd_push   = 1'b0;
    if (accept) begin
      case (func)
        FN_SPI: begin
          bcnt_nxt = cnt;
          case (cnt)
            2'd0: begin
              opcode_nxt = rx_byte;
              bcnt_nxt   = 2'd1;
            end
            2'd1: begin
              arg1_nxt = rx_byte;
              bcnt_nxt = 2'd2;
            end
            2'd2: begin
              bcnt_nxt = 2'd3;
              cmd.idx  = arg1_r;
              cmd.val  = rx_byte;
              case (opcode_r)
                OP_READ: begin
                  cmd.kind = CMD_READ;
                  cmd.stop = {1'b0, arg1_r} + 9'd1;
                  cmd_push = 1'b1;
                end
                OP_WRITE: begin
                  cmd.kind = CMD_WRITE;
                  cmd_push = 1'b1;
                end
                OP_RANGE: begin
                  cmd.kind = CMD_READ;
                  cmd.stop = stop_b;
                  cmd_push = (stop_b > {1'b0, arg1_r});
                end
                default: cmd_push = 1'b0;
              endcase
            end
            default: bcnt_nxt = 2'd3;  // bytes past the frame are dropped
          endcase
        end
        FN_LOCAL: begin
          cmd.kind = CMD_WRITE;
          cmd.idx  = {2'b00, local_index};
          cmd.val  = local_value;
          cmd_push = 1'b1;
        end
        FN_CLEAR: begin
          cmd.kind = CMD_CLEAR;
          cmd_push = 1'b1;
        end
        default: cmd_push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r   <= 2'd0;
      opcode_r <= 8'd0;
      arg1_r   <= 8'd0;
    end else begin
      bcnt_r   <= bcnt_nxt;
      opcode_r <= opcode_nxt;
      arg1_r   <= arg1_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/scb_cmdq.sv */
// Command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module scb_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire scb_pkg::cmd_t din,
  output logic               full,
  input  wire logic          pop,
  output scb_pkg::cmd_t      dout,
  output logic               empty
);
  import scb_pkg::*;

  cmd_t           mem [Q_DEPTH];
  logic [QPW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPW:0]   lvl_r, lvl_nxt;
  logic           do_push, do_pop;

  assign full    = (lvl_r == Q_DEPTH_L);
  assign empty   = (lvl_r == '0);
  assign dout    = mem[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    lvl_nxt = lvl_r + (QPW + 1)'(do_push) - (QPW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/scb_outq.sv */
// Result queue feeding the output ports.
`timescale 1ns / 1ps
`default_nettype none
module scb_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire scb_pkg::res_t        din,
  output logic [scb_pkg::QPW:0]     level,
  input  wire logic                 pop,
  output scb_pkg::res_t             dout,
  output logic                      empty
);
  import scb_pkg::*;

  res_t           mem [Q_DEPTH];
  logic [QPW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPW:0]   lvl_r, lvl_nxt;
  logic           do_push, do_pop;

  assign level   = lvl_r;
  assign empty   = (lvl_r == '0);
  assign dout    = mem[rp_r];
  assign do_push = push && (lvl_r != Q_DEPTH_L);
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    lvl_nxt = lvl_r + (QPW + 1)'(do_push) - (QPW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/scb_back.sv */
// Back end: byte store and commands; reads one entry a cycle unless held.
`timescale 1ns / 1ps
`default_nettype none
module scb_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire scb_pkg::cmd_t        cmd,
  input  wire logic                 cmd_empty,
  output logic                      cmd_pop,
  input  wire logic [scb_pkg::QPW:0] oq_level,
  output logic                      res_push,
  output scb_pkg::res_t             res
);
  import scb_pkg::*;

  logic [7:0]       store [DEPTH];
  logic [DEPTH-1:0] vld_r;

  bk_state_t  state_r, state_nxt;
  logic [8:0] cur_r, cur_nxt, stop_r, stop_nxt;
  logic       we, clr, rd_en;
  logic       cmd_in_range, cur_in_range, can_issue;
  logic       pend_r, hit_r, last_r;
  logic [7:0] data_r;

  assign cmd_in_range = ({1'b0, cmd.idx} < DEPTH_L);
  assign cur_in_range = (cur_r < DEPTH_L);
  // count the read in flight so the queue never overflows
  assign can_issue    = ((oq_level + (QPW + 1)'(pend_r)) < Q_DEPTH_L);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty && cmd.kind == CMD_READ) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (can_issue && (cur_r + 9'd1 == stop_r)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    we       = 1'b0;
    clr      = 1'b0;
    rd_en    = 1'b0;
    cur_nxt  = cur_r;
    stop_nxt = stop_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_WRITE: we = cmd_in_range;
            CMD_CLEAR: clr = 1'b1;
            CMD_READ: begin
              cur_nxt  = {1'b0, cmd.idx};
              stop_nxt = cmd.stop;
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      BK_RUN: begin
        if (can_issue) begin
          rd_en   = 1'b1;
          cur_nxt = cur_r + 9'd1;
        end
      end
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[cmd.idx[AW-1:0]] <= cmd.val;
    end
    if (rd_en) begin
      data_r <= store[cur_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= cur_in_range && vld_r[cur_r[AW-1:0]];
    last_r <= (cur_r + 9'd1 == stop_r);
    cur_r  <= cur_nxt;
    stop_r <= stop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      vld_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= rd_en;
      if (clr) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[cmd.idx[AW-1:0]] <= 1'b1;
      end
    end
  end

  assign res_push = pend_r;
  assign res.tx   = hit_r ? data_r : 8'd0;
  assign res.last = last_r;

endmodule
`default_nettype wire
